@@ rtl/pic_pkg.sv @@
// ----------------------------------------------------------------------------
// pic_pkg: shared types and codes for the ip range classifier
// operation codes, rule kinds, result word layout and kind decoding
// ----------------------------------------------------------------------------
`default_nettype none

package pic_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_HEADER = 2'd1,
    OP_RANGE  = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_WHITE  = 2'd1,
    KIND_BLACK  = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_t;

  localparam logic [1:0] VERDICT_PASS     = 2'd0;
  localparam logic [1:0] VERDICT_REDIRECT = 2'd1;
  localparam logic [1:0] VERDICT_REJECT   = 2'd2;

  localparam logic [1:0] AUTH_UNKNOWN = 2'd0;
  localparam logic [1:0] AUTH_WEB     = 2'd1;
  localparam logic [1:0] AUTH_AUTO    = 2'd2;

  // rule header fields of fixed width
  typedef struct packed {
    logic       enabled;
    kind_t      kind;
    logic [7:0] prio;
  } hdr_t;

  // one result word
  typedef struct packed {
    logic [1:0] verdict;
    logic [1:0] auth_kind;
    logic       hit;
    logic [3:0] hit_slot;
  } res_t;

  localparam res_t RES_NONE = '{
    verdict:   VERDICT_PASS,
    auth_kind: AUTH_UNKNOWN,
    hit:       1'b0,
    hit_slot:  4'd0
  };

  function automatic res_t make_res(input logic hit, input kind_t kind,
                                    input logic [3:0] slot);
    res_t r;
    r = RES_NONE;
    if (hit) begin
      r.hit      = 1'b1;
      r.hit_slot = slot;
      unique case (kind)
        KIND_NORMAL: begin
          r.verdict   = VERDICT_REDIRECT;
          r.auth_kind = AUTH_WEB;
        end
        KIND_WHITE: begin
          r.verdict   = VERDICT_PASS;
          r.auth_kind = AUTH_AUTO;
        end
        KIND_BLACK: begin
          r.verdict   = VERDICT_REJECT;
          r.auth_kind = AUTH_UNKNOWN;
        end
        KIND_OTHER: begin
          r.verdict   = VERDICT_PASS;
          r.auth_kind = AUTH_UNKNOWN;
        end
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pic_rule_store.sv @@
// ----------------------------------------------------------------------------
// pic_rule_store: rule header memory with per-slot valid marks
// one write port, one registered read port, valid marks cleared at once
// ----------------------------------------------------------------------------
`default_nettype none

module pic_rule_store #(
  parameter int RULE_SLOTS      = 16,
  parameter int RANGES_PER_RULE = 4,
  localparam int SI_W  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1,
  localparam int CNT_W = $clog2(RANGES_PER_RULE + 1)
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   clear_i,
  input  wire                   we_i,
  input  wire  [SI_W-1:0]       wr_slot_i,
  input  pic_pkg::hdr_t         wr_hdr_i,
  input  wire  [CNT_W-1:0]      wr_cnt_i,
  input  wire  [SI_W-1:0]       rd_slot_i,
  output logic                  rd_valid_o,
  output pic_pkg::hdr_t         rd_hdr_o,
  output logic [CNT_W-1:0]      rd_cnt_o
);

  typedef struct packed {
    pic_pkg::hdr_t    hdr;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  logic [RULE_SLOTS-1:0] valid_r;
  entry_t                mem [RULE_SLOTS];
  entry_t                rd_entry_r;
  logic                  rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clear_i) begin
      valid_r <= '0;
    end else if (we_i) begin
      valid_r[wr_slot_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[wr_slot_i] <= '{hdr: wr_hdr_i, cnt: wr_cnt_i};
    end
    rd_entry_r <= mem[rd_slot_i];
    rd_valid_r <= valid_r[rd_slot_i];
  end

  assign rd_valid_o = rd_valid_r;
  assign rd_hdr_o   = rd_entry_r.hdr;
  assign rd_cnt_o   = rd_entry_r.cnt;

endmodule

`default_nettype wire

@@ rtl/pic_range_store.sv @@
// ----------------------------------------------------------------------------
// pic_range_store: address range memory, RANGES_PER_RULE rows per rule
// one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pic_range_store #(
  parameter int RULE_SLOTS      = 16,
  parameter int RANGES_PER_RULE = 4,
  localparam int SI_W  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1,
  localparam int RI_W  = (RANGES_PER_RULE > 1) ? $clog2(RANGES_PER_RULE) : 1
) (
  input  wire              clk,
  input  wire              we_i,
  input  wire  [SI_W-1:0]  wr_slot_i,
  input  wire  [RI_W-1:0]  wr_rng_i,
  input  wire  [31:0]      wr_low_i,
  input  wire  [31:0]      wr_high_i,
  input  wire  [SI_W-1:0]  rd_slot_i,
  input  wire  [RI_W-1:0]  rd_rng_i,
  output logic [31:0]      rd_low_o,
  output logic [31:0]      rd_high_o
);

  localparam int DEPTH = RULE_SLOTS * RANGES_PER_RULE;
  localparam int RA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [RA_W-1:0] ROW_STEP = RA_W'(RANGES_PER_RULE);

  logic [63:0]     mem [DEPTH];
  logic [63:0]     rd_data_r;
  logic [RA_W-1:0] wr_addr;
  logic [RA_W-1:0] rd_addr;

  assign wr_addr = RA_W'(wr_slot_i) * ROW_STEP + RA_W'(wr_rng_i);
  assign rd_addr = RA_W'(rd_slot_i) * ROW_STEP + RA_W'(rd_rng_i);

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[wr_addr] <= {wr_high_i, wr_low_i};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_low_o  = rd_data_r[31:0];
  assign rd_high_o = rd_data_r[63:32];

endmodule

`default_nettype wire

@@ rtl/pic_walker.sv @@
// ----------------------------------------------------------------------------
// pic_walker: lookup sequencer over the rule and range memories
// one range compare per cycle, best match kept by priority
// ----------------------------------------------------------------------------
`default_nettype none

module pic_walker #(
  parameter int RULE_SLOTS      = 16,
  parameter int RANGES_PER_RULE = 4,
  localparam int SI_W  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1,
  localparam int RI_W  = (RANGES_PER_RULE > 1) ? $clog2(RANGES_PER_RULE) : 1,
  localparam int CNT_W = $clog2(RANGES_PER_RULE + 1)
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start_i,
  input  wire                 scan_i,
  input  wire  [31:0]         addr_i,
  input  wire                 hdr_valid_i,
  input  pic_pkg::hdr_t       hdr_i,
  input  wire  [CNT_W-1:0]    hdr_cnt_i,
  input  wire  [31:0]         rng_low_i,
  input  wire  [31:0]         rng_high_i,
  output logic [SI_W-1:0]     rd_slot_o,
  output logic [RI_W-1:0]     rd_rng_o,
  output logic                done_o,
  output pic_pkg::res_t       res_o
);

  logic [SI_W-1:0]   slot_r, slot_nxt;
  logic [RI_W-1:0]   rng_r, rng_nxt;
  logic [31:0]       addr_r;
  logic              found_r;
  logic [SI_W-1:0]   best_slot_r;
  logic [7:0]        best_prio_r;
  pic_pkg::kind_t    best_kind_r;

  logic              rng_live;
  logic              in_rng;
  logic              match;
  logic              more;
  logic              last_slot;

  // entry counts only while the rule could still beat the current best
  assign rng_live  = hdr_valid_i && hdr_i.enabled &&
                     (!found_r || (hdr_i.prio > best_prio_r)) &&
                     (CNT_W'(rng_r) < hdr_cnt_i);
  assign in_rng    = (addr_r >= rng_low_i) && (addr_r <= rng_high_i);
  assign match     = scan_i && rng_live && in_rng;
  assign more      = rng_live && !in_rng &&
                     ((CNT_W'(rng_r) + CNT_W'(1)) < hdr_cnt_i);
  assign last_slot = (slot_r == SI_W'(RULE_SLOTS - 1));
  assign done_o    = scan_i && !more && last_slot;

  always_comb begin
    slot_nxt = slot_r;
    rng_nxt  = rng_r;
    if (start_i) begin
      slot_nxt = '0;
      rng_nxt  = '0;
    end else if (scan_i) begin
      if (more) begin
        rng_nxt = rng_r + RI_W'(1);
      end else begin
        slot_nxt = last_slot ? '0 : slot_r + SI_W'(1);
        rng_nxt  = '0;
      end
    end
  end

  // read address for the next cycle
  assign rd_slot_o = slot_nxt;
  assign rd_rng_o  = rng_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      rng_r   <= '0;
      found_r <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      rng_r  <= rng_nxt;
      if (start_i) begin
        found_r <= 1'b0;
      end else if (match) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      addr_r <= addr_i;
    end
    if (match) begin
      best_slot_r <= slot_r;
      best_prio_r <= hdr_i.prio;
      best_kind_r <= hdr_i.kind;
    end
  end

  assign res_o = pic_pkg::make_res(found_r || match,
                                   match ? hdr_i.kind : best_kind_r,
                                   4'(match ? slot_r : best_slot_r));

endmodule

`default_nettype wire

@@ rtl/priority_ip_range_classifier_top.sv @@
// ----------------------------------------------------------------------------
// priority_ip_range_classifier_top: ipv4 range rule classifier
// rule table in two memories, lookups walk it one range per cycle
// ----------------------------------------------------------------------------
//
// channel | direction | handshake           | word
// --------+-----------+---------------------+-----------------------------------
// in_     | input     | in_valid / in_ready | operation, slots, range, header,
//         |           |                     | address to look up
// out_    | output    | out_valid/out_ready | verdict, auth_kind, hit, hit_slot
//
// clear, header and range writes answer without a walk (the result word goes
// straight to the output register when that register is free)
// a lookup visits every rule slot in turn and reads a further range of a rule
// only while that rule is still in the race, one range at a time through the
// single read port of the range memory and its compare
// one item is worked on at a time; a finished word waits in a hold register
// while the output register is still occupied, and the next item is taken
// once the hold register has moved on
// reset clears the valid marks of all slots at once; no clearing pass
//
`default_nettype none

module priority_ip_range_classifier_top #(
  parameter int RULE_SLOTS      = 16,
  parameter int RANGES_PER_RULE = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_operation,
  input  wire  [3:0]  in_rule_slot,
  input  wire  [1:0]  in_range_slot,
  input  wire  [31:0] in_range_low,
  input  wire  [31:0] in_range_high,
  input  wire  [1:0]  in_rule_kind,
  input  wire  [7:0]  in_rule_priority,
  input  wire         in_rule_enabled,
  input  wire  [2:0]  in_range_count,
  input  wire  [31:0] in_ipv4_address,
  // result channel
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_verdict,
  output logic [1:0]  out_auth_kind,
  output logic        out_hit,
  output logic [3:0]  out_hit_slot
);

  localparam int SI_W  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int RI_W  = (RANGES_PER_RULE > 1) ? $clog2(RANGES_PER_RULE) : 1;
  localparam int CNT_W = $clog2(RANGES_PER_RULE + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  state_t          state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  pic_pkg::res_t   out_res_r, out_res_nxt;
  pic_pkg::res_t   hold_res_r, hold_res_nxt;

  logic            accept;
  logic            out_free;
  logic            slot_ok;
  logic            rng_ok;
  logic            clear_we;
  logic            hdr_we;
  logic            rng_we;
  logic            lookup_go;
  logic [CNT_W-1:0] cnt_sat;
  pic_pkg::hdr_t   wr_hdr;

  logic            produce;
  pic_pkg::res_t   prod_res;

  // memory read side and walker
  logic [SI_W-1:0]  rd_slot;
  logic [RI_W-1:0]  rd_rng;
  logic             rd_valid;
  pic_pkg::hdr_t    rd_hdr;
  logic [CNT_W-1:0] rd_cnt;
  logic [31:0]      rd_low;
  logic [31:0]      rd_high;
  logic             walk_done;
  pic_pkg::res_t    walk_res;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // out-of-table slots are dropped silently, the item still answers
  assign slot_ok = (32'(in_rule_slot) < RULE_SLOTS);
  assign rng_ok  = (32'(in_range_slot) < RANGES_PER_RULE);

  // range count saturates at the rows a rule owns
  assign cnt_sat = (32'(in_range_count) > RANGES_PER_RULE) ?
                   CNT_W'(RANGES_PER_RULE) : CNT_W'(in_range_count);

  assign wr_hdr = '{enabled: in_rule_enabled,
                    kind:    pic_pkg::kind_t'(in_rule_kind),
                    prio:    in_rule_priority};

  // operation decode
  always_comb begin
    clear_we  = 1'b0;
    hdr_we    = 1'b0;
    rng_we    = 1'b0;
    lookup_go = 1'b0;
    if (accept) begin
      unique case (pic_pkg::op_t'(in_operation))
        pic_pkg::OP_CLEAR:  clear_we  = 1'b1;
        pic_pkg::OP_HEADER: hdr_we    = slot_ok;
        pic_pkg::OP_RANGE:  rng_we    = slot_ok && rng_ok;
        pic_pkg::OP_LOOKUP: lookup_go = 1'b1;
      endcase
    end
  end

  pic_rule_store #(
    .RULE_SLOTS      (RULE_SLOTS),
    .RANGES_PER_RULE (RANGES_PER_RULE)
  ) u_rule_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear_i    (clear_we),
    .we_i       (hdr_we),
    .wr_slot_i  (SI_W'(in_rule_slot)),
    .wr_hdr_i   (wr_hdr),
    .wr_cnt_i   (cnt_sat),
    .rd_slot_i  (rd_slot),
    .rd_valid_o (rd_valid),
    .rd_hdr_o   (rd_hdr),
    .rd_cnt_o   (rd_cnt)
  );

  pic_range_store #(
    .RULE_SLOTS      (RULE_SLOTS),
    .RANGES_PER_RULE (RANGES_PER_RULE)
  ) u_range_store (
    .clk       (clk),
    .we_i      (rng_we),
    .wr_slot_i (SI_W'(in_rule_slot)),
    .wr_rng_i  (RI_W'(in_range_slot)),
    .wr_low_i  (in_range_low),
    .wr_high_i (in_range_high),
    .rd_slot_i (rd_slot),
    .rd_rng_i  (rd_rng),
    .rd_low_o  (rd_low),
    .rd_high_o (rd_high)
  );

  // the walker drives the read address; on the accept edge of a lookup it
  // points at slot 0 range 0 so the first entry arrives in the first scan cycle
  pic_walker #(
    .RULE_SLOTS      (RULE_SLOTS),
    .RANGES_PER_RULE (RANGES_PER_RULE)
  ) u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (lookup_go),
    .scan_i      (state_r == ST_SCAN),
    .addr_i      (in_ipv4_address),
    .hdr_valid_i (rd_valid),
    .hdr_i       (rd_hdr),
    .hdr_cnt_i   (rd_cnt),
    .rng_low_i   (rd_low),
    .rng_high_i  (rd_high),
    .rd_slot_o   (rd_slot),
    .rd_rng_o    (rd_rng),
    .done_o      (walk_done),
    .res_o       (walk_res)
  );

  // control and output register
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    hold_res_nxt  = hold_res_r;
    produce       = 1'b0;
    prod_res      = pic_pkg::RES_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (lookup_go) begin
          state_nxt = ST_SCAN;
        end else if (accept) begin
          // writes and clears answer with the all-zero word
          produce = 1'b1;
        end
      end
      ST_SCAN: begin
        if (walk_done) begin
          produce  = 1'b1;
          prod_res = walk_res;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_res_nxt   = hold_res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (produce) begin
      if (out_free) begin
        out_res_nxt   = prod_res;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end else begin
        hold_res_nxt = prod_res;
        state_nxt    = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    hold_res_r <= hold_res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_verdict   = out_res_r.verdict;
  assign out_auth_kind = out_res_r.auth_kind;
  assign out_hit       = out_res_r.hit;
  assign out_hit_slot  = out_res_r.hit_slot;

`ifndef NO_ASSERTIONS
  // a word is only parked while the output register is occupied
  a_hold_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("hold state with empty output register");

  // a miss or a non-lookup word carries pass, unknown and slot zero
  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.hit) |->
      (out_res_r.verdict == pic_pkg::VERDICT_PASS) &&
      (out_res_r.auth_kind == pic_pkg::AUTH_UNKNOWN) &&
      (out_res_r.hit_slot == 4'd0))
    else $error("miss word not all zero");

  // a write item with a free output register answers in the next cycle
  a_write_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !lookup_go && out_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("write item did not answer at once");

  // a hit always names a rule slot inside the table
  a_hit_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.hit) |-> (32'(out_res_r.hit_slot) < RULE_SLOTS))
    else $error("hit slot outside the table");
`endif

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: regression bench for priority_ip_range_classifier_top
// builds rule tables and lookups, predicts every result word in order and
// compares it field by field while both channels idle and stall at random
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 16;
  localparam int RANGES       = 4;
  localparam int ITEM_TARGET  = 550;
  // slowest lookup walks every range of every slot
  localparam int DRAIN_CYCLES = SLOTS * RANGES + 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  // one input word, all fields
  typedef struct {
    pic_pkg::op_t   op;
    logic [3:0]     rule_slot;
    logic [1:0]     range_slot;
    logic [31:0]    range_low;
    logic [31:0]    range_high;
    pic_pkg::kind_t kind;
    logic [7:0]     prio;
    logic           en;
    logic [2:0]     count;
    logic [31:0]    addr;
  } cls_item_t;

  logic clk;
  logic rst_n = 1'b0;

  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation     = '0;
  logic [3:0]  in_rule_slot     = '0;
  logic [1:0]  in_range_slot    = '0;
  logic [31:0] in_range_low     = '0;
  logic [31:0] in_range_high    = '0;
  logic [1:0]  in_rule_kind     = '0;
  logic [7:0]  in_rule_priority = '0;
  logic        in_rule_enabled  = 1'b0;
  logic [2:0]  in_range_count   = '0;
  logic [31:0] in_ipv4_address  = '0;

  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [1:0]  out_verdict;
  logic [1:0]  out_auth_kind;
  logic        out_hit;
  logic [3:0]  out_hit_slot;

  priority_ip_range_classifier_top #(
    .RULE_SLOTS      (SLOTS),
    .RANGES_PER_RULE (RANGES)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_rule_slot     (in_rule_slot),
    .in_range_slot    (in_range_slot),
    .in_range_low     (in_range_low),
    .in_range_high    (in_range_high),
    .in_rule_kind     (in_rule_kind),
    .in_rule_priority (in_rule_priority),
    .in_rule_enabled  (in_rule_enabled),
    .in_range_count   (in_range_count),
    .in_ipv4_address  (in_ipv4_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_verdict      (out_verdict),
    .out_auth_kind    (out_auth_kind),
    .out_hit          (out_hit),
    .out_hit_slot     (out_hit_slot)
  );

  // words waiting to be sent, and predicted result words in arrival order
  cls_item_t     pending_items[$];
  pic_pkg::res_t expected_results[$];
  cls_item_t     cur_item;

  int accepted_count = 0;
  int total_items    = 1;
  int fault_count    = 0;
  int cycle_count    = 0;

  // ---------------------------------------------------------------------------
  // rule table as the block should hold it, updated on each accepted word
  // ---------------------------------------------------------------------------
  bit             tbl_valid [SLOTS] = '{default: 1'b0};
  bit             tbl_enabled [SLOTS];
  pic_pkg::kind_t tbl_kind [SLOTS];
  logic [7:0]     tbl_prio [SLOTS];
  logic [2:0]     tbl_count [SLOTS];
  logic [31:0]    tbl_low [SLOTS*RANGES];
  logic [31:0]    tbl_high [SLOTS*RANGES];

  // applies one word to the table and returns the result word it yields
  function automatic pic_pkg::res_t classify_item(cls_item_t it);
    pic_pkg::res_t r;
    int            idx;
    bit            found;
    bit            holds;
    int            best;
    r     = '0;
    found = 1'b0;
    best  = 0;
    case (it.op)
      pic_pkg::OP_CLEAR: begin
        foreach (tbl_valid[s]) tbl_valid[s] = 1'b0;
      end
      pic_pkg::OP_HEADER: begin
        tbl_valid[it.rule_slot]   = 1'b1;
        tbl_enabled[it.rule_slot] = it.en;
        tbl_kind[it.rule_slot]    = it.kind;
        tbl_prio[it.rule_slot]    = it.prio;
        // counts above the per-rule range limit saturate
        tbl_count[it.rule_slot]   = (it.count > RANGES) ? 3'(RANGES) : it.count;
      end
      pic_pkg::OP_RANGE: begin
        idx = it.rule_slot * RANGES + it.range_slot;
        tbl_low[idx]  = it.range_low;
        tbl_high[idx] = it.range_high;
      end
      pic_pkg::OP_LOOKUP: begin
        // strictly higher priority replaces, so ties stay with the lower slot
        for (int s = 0; s < SLOTS; s++) begin
          if (tbl_valid[s] && tbl_enabled[s] && (!found || tbl_prio[s] > tbl_prio[best])) begin
            holds = 1'b0;
            for (int g = 0; g < tbl_count[s]; g++) begin
              idx = s * RANGES + g;
              // an inverted range holds nothing, which falls out of the compare
              if (it.addr >= tbl_low[idx] && it.addr <= tbl_high[idx]) holds = 1'b1;
            end
            if (holds) begin
              found = 1'b1;
              best  = s;
            end
          end
        end
        if (found) begin
          r.hit      = 1'b1;
          r.hit_slot = 4'(best);
          case (tbl_kind[best])
            pic_pkg::KIND_NORMAL: begin
              r.verdict   = pic_pkg::VERDICT_REDIRECT;
              r.auth_kind = pic_pkg::AUTH_WEB;
            end
            pic_pkg::KIND_WHITE: begin
              r.verdict   = pic_pkg::VERDICT_PASS;
              r.auth_kind = pic_pkg::AUTH_AUTO;
            end
            pic_pkg::KIND_BLACK: begin
              r.verdict   = pic_pkg::VERDICT_REJECT;
              r.auth_kind = pic_pkg::AUTH_UNKNOWN;
            end
            default: begin
              r.verdict   = pic_pkg::VERDICT_PASS;
              r.auth_kind = pic_pkg::AUTH_UNKNOWN;
            end
          endcase
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus planning: a shadow of the table as the queued words will leave
  // it, so lookups can aim at stored ranges and no valid rule ever points at
  // a range entry that was never written
  // ---------------------------------------------------------------------------
  bit          plan_valid [SLOTS]          = '{default: 1'b0};
  bit          plan_enabled [SLOTS]        = '{default: 1'b0};
  int          plan_count [SLOTS]          = '{default: 0};
  bit          plan_written [SLOTS*RANGES] = '{default: 1'b0};
  logic [31:0] plan_low [SLOTS*RANGES];
  logic [31:0] plan_high [SLOTS*RANGES];

  // every field random, so bits unused by the operation toggle too
  function automatic cls_item_t rand_item();
    cls_item_t it;
    it.op         = pic_pkg::op_t'($urandom_range(0, 3));
    it.rule_slot  = 4'($urandom);
    it.range_slot = 2'($urandom);
    it.range_low  = $urandom;
    it.range_high = $urandom;
    it.kind       = pic_pkg::kind_t'($urandom_range(0, 3));
    it.prio       = 8'($urandom);
    it.en         = 1'($urandom);
    it.count      = 3'($urandom);
    it.addr       = $urandom;
    return it;
  endfunction

  function automatic void push_item(cls_item_t it);
    int idx;
    case (it.op)
      pic_pkg::OP_CLEAR: begin
        foreach (plan_valid[s]) plan_valid[s] = 1'b0;
      end
      pic_pkg::OP_HEADER: begin
        plan_valid[it.rule_slot]   = 1'b1;
        plan_enabled[it.rule_slot] = it.en;
        plan_count[it.rule_slot]   = (it.count > RANGES) ? RANGES : it.count;
      end
      pic_pkg::OP_RANGE: begin
        idx = it.rule_slot * RANGES + it.range_slot;
        plan_written[idx] = 1'b1;
        plan_low[idx]     = it.range_low;
        plan_high[idx]    = it.range_high;
      end
      default: ;
    endcase
    pending_items.push_back(it);
  endfunction

  function automatic void make_range(output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] bases [5] = '{32'h0A00_0000, 32'hC0A8_0000, 32'hAC10_0000,
                               32'hFFFF_FF00, 32'h0000_0000};
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      lo = $urandom;
      hi = $urandom;
    end else if (mode < 18) begin
      // inverted on purpose
      hi = bases[$urandom_range(0, 4)] + $urandom_range(0, 255);
      lo = hi + $urandom_range(1, 300);
    end else if (mode < 25) begin
      lo = bases[$urandom_range(0, 4)] + $urandom_range(0, 511);
      hi = lo;
    end else if (mode < 30) begin
      lo = 32'h0000_0000;
      hi = 32'hFFFF_FFFF;
    end else begin
      // overlapping neighborhoods make priority order matter
      lo = bases[$urandom_range(0, 4)] + $urandom_range(0, 511);
      hi = lo + $urandom_range(0, 767);
    end
  endfunction

  function automatic void push_range(int slot, int g, logic [31:0] lo, logic [31:0] hi);
    cls_item_t it;
    it            = rand_item();
    it.op         = pic_pkg::OP_RANGE;
    it.rule_slot  = 4'(slot);
    it.range_slot = 2'(g);
    it.range_low  = lo;
    it.range_high = hi;
    push_item(it);
  endfunction

  // fills any never-written range the header would bring into use first
  function automatic void push_header(int slot, pic_pkg::kind_t kind, logic [7:0] prio,
                                      logic en, logic [2:0] count);
    cls_item_t   it;
    int          used;
    logic [31:0] lo;
    logic [31:0] hi;
    used = (count > RANGES) ? RANGES : count;
    for (int g = 0; g < used; g++) begin
      if (!plan_written[slot * RANGES + g]) begin
        make_range(lo, hi);
        push_range(slot, g, lo, hi);
      end
    end
    it           = rand_item();
    it.op        = pic_pkg::OP_HEADER;
    it.rule_slot = 4'(slot);
    it.kind      = kind;
    it.prio      = prio;
    it.en        = en;
    it.count     = count;
    push_item(it);
  endfunction

  function automatic void push_lookup(logic [31:0] addr);
    cls_item_t it;
    it      = rand_item();
    it.op   = pic_pkg::OP_LOOKUP;
    it.addr = addr;
    push_item(it);
  endfunction

  function automatic void push_clear();
    cls_item_t it;
    it    = rand_item();
    it.op = pic_pkg::OP_CLEAR;
    push_item(it);
  endfunction

  // aims inside a live range, at range edges, near the 0A00_0000 base, or anywhere
  function automatic logic [31:0] pick_address();
    int          live [$];
    int          stored [$];
    int          mode;
    int          s;
    int          idx;
    logic [31:0] lo;
    logic [31:0] hi;
    mode = $urandom_range(0, 99);
    foreach (plan_valid[k])
      if (plan_valid[k] && plan_enabled[k] && plan_count[k] > 0) live.push_back(k);
    foreach (plan_written[k])
      if (plan_written[k]) stored.push_back(k);
    if (mode < 55 && live.size() > 0) begin
      s   = live[$urandom_range(0, live.size() - 1)];
      idx = s * RANGES + $urandom_range(0, plan_count[s] - 1);
      lo  = plan_low[idx];
      hi  = plan_high[idx];
      if (lo > hi) return lo;
      if (hi - lo == 32'hFFFF_FFFF) return $urandom;
      return lo + ($urandom % (hi - lo + 32'd1));
    end
    if (mode < 80 && stored.size() > 0) begin
      idx = stored[$urandom_range(0, stored.size() - 1)];
      case ($urandom_range(0, 3))
        0:       return plan_low[idx] - 32'd1;
        1:       return plan_low[idx];
        2:       return plan_high[idx];
        default: return plan_high[idx] + 32'd1;
      endcase
    end
    if (mode < 88) return 32'h0A00_0000 + $urandom_range(0, 1023);
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // idling phases, stepped by how far through the run the sender is:
  // none, sender gaps, receiver stalls, then a light mix of both
  // ---------------------------------------------------------------------------
  function automatic int run_phase();
    int p;
    p = accepted_count * 4 / total_items;
    return (p > 3) ? 3 : p;
  endfunction

  function automatic int send_idle_pct();
    case (run_phase())
      1:       return 59;
      3:       return 8;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (run_phase())
      2:       return 59;
      3:       return 8;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // driver: holds the word until accepted, then predicts its result and
  // presents the next one unless this cycle is an idle one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    bit took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        expected_results.push_back(classify_item(cur_item));
        accepted_count++;
      end
      // valid changes only once per edge: either a fresh word or a drop
      if (!in_valid || took) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          cur_item          = pending_items.pop_front();
          in_operation     <= cur_item.op;
          in_rule_slot     <= cur_item.rule_slot;
          in_range_slot    <= cur_item.range_slot;
          in_range_low     <= cur_item.range_low;
          in_range_high    <= cur_item.range_high;
          in_rule_kind     <= cur_item.kind;
          in_rule_priority <= cur_item.prio;
          in_rule_enabled  <= cur_item.en;
          in_range_count   <= cur_item.count;
          in_ipv4_address  <= cur_item.addr;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each accepted result word against the oldest prediction
  // and drives out_ready with random stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    pic_pkg::res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("unexpected result word: verdict=%0d auth=%0d hit=%0d slot=%0d",
                     out_verdict, out_auth_kind, out_hit, out_hit_slot);
        end else begin
          want = expected_results.pop_front();
          if (out_verdict !== want.verdict || out_auth_kind !== want.auth_kind ||
              out_hit !== want.hit || out_hit_slot !== want.hit_slot) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display("mismatch: exp v=%0d a=%0d h=%0d s=%0d got v=%0d a=%0d h=%0d s=%0d",
                       want.verdict, want.auth_kind, want.hit, want.hit_slot,
                       out_verdict, out_auth_kind, out_hit, out_hit_slot);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // run limit
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("priority_ip_range_classifier_top regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : main
    int          pick;
    int          slot;
    int          used;
    logic [2:0]  count;
    logic [31:0] lo;
    logic [31:0] hi;

    // directed: empty table misses
    push_lookup(32'h0000_0000);
    // catch-all rule at the lowest priority, top address hits it
    push_range(0, 0, 32'h0000_0000, 32'hFFFF_FFFF);
    push_header(0, pic_pkg::KIND_NORMAL, 8'd0, 1'b1, 3'd1);
    push_lookup(32'hFFFF_FFFF);
    // ranges land before their header; inverted, single-address and wide ones
    push_range(15, 0, 32'hFFFF_FFFF, 32'h0000_0000);
    push_range(15, 1, 32'h0A00_0001, 32'h0A00_0001);
    push_range(15, 2, 32'h0A00_0010, 32'h0A00_001F);
    push_range(15, 3, 32'hC0A8_0000, 32'hC0A8_FFFF);
    // count beyond the range limit saturates
    push_header(15, pic_pkg::KIND_WHITE, 8'd255, 1'b1, 3'd7);
    push_lookup(32'h0A00_0001);
    push_lookup(32'hC0A8_FFFF);
    push_lookup(32'h8000_0000);
    // equal priority: the lower slot wins
    push_range(7, 0, 32'h0A00_0000, 32'h0AFF_FFFF);
    push_header(7, pic_pkg::KIND_BLACK, 8'd255, 1'b1, 3'd1);
    push_lookup(32'h0A00_0001);
    // disabled rule is skipped, then enabled it takes over
    push_range(3, 0, 32'h0A00_0000, 32'h0A00_00FF);
    push_header(3, pic_pkg::KIND_OTHER, 8'd200, 1'b0, 3'd1);
    push_lookup(32'h0A00_0005);
    push_header(3, pic_pkg::KIND_OTHER, 8'd255, 1'b1, 3'd1);
    push_lookup(32'h0A00_0005);
    // rule with no ranges never matches
    push_header(9, pic_pkg::KIND_NORMAL, 8'd255, 1'b1, 3'd0);
    // clear drops every rule; stored ranges come back with a new header
    push_clear();
    push_lookup(32'h0A00_0001);
    push_header(15, pic_pkg::KIND_WHITE, 8'd1, 1'b1, 3'd4);
    push_lookup(32'h0A00_0012);

    // random: mostly rule sets followed by lookups, with loose writes mixed in
    while (pending_items.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        push_clear();
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 3)) begin
          slot  = $urandom_range(0, SLOTS - 1);
          count = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, RANGES));
          used  = (count > RANGES) ? RANGES : count;
          for (int g = 0; g < used; g++) begin
            if ($urandom_range(0, 4) != 0) begin
              make_range(lo, hi);
              push_range(slot, g, lo, hi);
            end
          end
          push_header(slot, pic_pkg::kind_t'($urandom_range(0, 3)),
                      ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 7)) : 8'($urandom),
                      ($urandom_range(0, 99) < 85), count);
        end
        repeat ($urandom_range(2, 8)) push_lookup(pick_address());
      end else if (pick < 75) begin
        make_range(lo, hi);
        push_range($urandom_range(0, SLOTS - 1), $urandom_range(0, RANGES - 1), lo, hi);
      end else if (pick < 82) begin
        push_header($urandom_range(0, SLOTS - 1), pic_pkg::kind_t'($urandom_range(0, 3)),
                    8'($urandom), 1'($urandom), 3'($urandom));
      end else begin
        push_lookup(pick_address());
      end
    end
    total_items = pending_items.size();

    // reset held low at the start, then released once
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // sample away from the active edge so counters are settled
    while (!(accepted_count == total_items && expected_results.size() == 0))
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) fault_count++;

    if (fault_count == 0) begin
      $display("priority_ip_range_classifier_top regression: pass");
    end else begin
      $display("priority_ip_range_classifier_top regression: fail");
    end
    $finish;
  end

endmodule
